FILE: design/lpht_pkg.sv
// Package for the linear probing hash table: item structs, command and
// status codes, and the control/status bundles between controller and datapath.
// No dependencies.
package lpht_pkg;

  localparam int KEY_W      = 31;
  localparam int CMD_W      = 2;
  localparam int STAT_W     = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic clear_en;
    logic load;
    logic hash_en;
    logic probe_en;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clear_done;
    logic hash_done;
    logic hit;
    logic miss;
  } dp_stat_t;

endpackage

FILE: design/lpht_dp.sv
// Datapath for the linear probing hash table: slot memory, key remainder
// unit, probe address/counters, compare logic and result register.
// Depends on lpht_pkg.
module lpht_dp #(
  parameter int TABLE_SIZE = 127
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lpht_pkg::ctrl_cmd_t  cmd,
  input  lpht_pkg::in_item_t   in_item,
  output lpht_pkg::dp_stat_t   stat,
  output lpht_pkg::out_item_t  out_item
);
  import lpht_pkg::*;

  localparam int SW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam logic [SW-1:0] LAST_SL = SW'(TABLE_SIZE - 1);
  localparam logic [CW-1:0] TS_C    = CW'(TABLE_SIZE);
  localparam logic [CW-1:0] LAST_C  = CW'(TABLE_SIZE - 1);
  // Reciprocal ceil(2^SH / TABLE_SIZE) gives the exact quotient for every key.
  localparam int              SH      = KEY_W + SW;
  localparam logic [63:0]     RECIP_W = ((64'd1 << SH) + 64'(TABLE_SIZE - 1)) /
                                        64'(TABLE_SIZE);
  localparam logic [KEY_W:0]  RECIP_M = (KEY_W+1)'(RECIP_W);
  localparam logic [KEY_W-1:0] TS_K   = KEY_W'(TABLE_SIZE);

  // Slot memory: {valid, key}.
  logic [KEY_W:0] mem [TABLE_SIZE];
  logic [KEY_W:0] rd_data_r;

  logic [SW-1:0]         clr_addr_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [KEY_W-1:0]      key_r;
  logic                  hash_ph_r;
  logic [KEY_W-1:0]      quo_r;
  logic [SW-1:0]         probe_addr_r;
  logic [SW-1:0]         chk_addr_r;
  logic                  chk_vld_r;
  logic [CW-1:0]         iss_cnt_r;
  logic [CW-1:0]         chk_cnt_r;
  out_item_t             res_r;

  logic [2*KEY_W:0] prod;
  logic [KEY_W-1:0] qd;
  logic [KEY_W-1:0] rem_full;
  logic [SW-1:0]    rem_nxt;
  logic          hash_last;
  logic          issuing;
  logic          is_ins;
  logic          match;
  logic          hit;
  logic          miss;
  logic          wr_en;
  logic [KEY_W:0] wr_data;

  // Quotient by reciprocal multiply is registered first; then multiply back and subtract.
  assign prod      = key_r * RECIP_M;
  assign qd        = quo_r * TS_K;
  assign rem_full  = key_r - qd;
  assign rem_nxt   = rem_full[SW-1:0];
  assign hash_last = hash_ph_r;

  assign issuing = cmd.probe_en && (iss_cnt_r != TS_C);
  assign is_ins  = (cmd_r == CMD_INSERT);
  assign match   = is_ins ? !rd_data_r[KEY_W]
                          : (rd_data_r[KEY_W] && (rd_data_r[KEY_W-1:0] == key_r));
  assign hit     = cmd.probe_en && chk_vld_r && match;
  assign miss    = cmd.probe_en && chk_vld_r && !match && (chk_cnt_r == LAST_C);

  assign wr_en   = hit && (cmd_r != CMD_SEARCH);
  assign wr_data = is_ins ? {1'b1, key_r} : {1'b0, rd_data_r[KEY_W-1:0]};

  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[chk_addr_r] <= wr_data;
    end
    rd_data_r <= mem[probe_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear_en) begin
      clr_addr_r <= (clr_addr_r == LAST_SL) ? '0 : clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
    end else begin
      chk_vld_r <= issuing;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= in_item.command;
      key_r      <= in_item.key;
      hash_ph_r  <= 1'b0;
      res_r      <= '{status: STAT_DONE, found: 1'b0};
    end
    if (cmd.hash_en) begin
      hash_ph_r <= 1'b1;
      if (hash_last) begin
        probe_addr_r <= rem_nxt;
        iss_cnt_r    <= '0;
        chk_cnt_r    <= '0;
      end else begin
        quo_r <= KEY_W'(prod >> SH);
      end
    end
    if (issuing) begin
      probe_addr_r <= (probe_addr_r == LAST_SL) ? '0 : probe_addr_r + 1'b1;
      iss_cnt_r    <= iss_cnt_r + 1'b1;
      chk_addr_r   <= probe_addr_r;
    end
    if (cmd.probe_en && chk_vld_r) begin
      chk_cnt_r <= chk_cnt_r + 1'b1;
    end
    if (hit) begin
      res_r <= '{status: STAT_DONE, found: !is_ins};
    end else if (miss) begin
      res_r <= is_ins ? '{status: STAT_FULL, found: 1'b0}
                      : '{status: STAT_ABSENT, found: 1'b0};
    end
  end

  assign stat.clear_done = cmd.clear_en && (clr_addr_r == LAST_SL);
  assign stat.hash_done  = cmd.hash_en && hash_last;
  assign stat.hit        = hit;
  assign stat.miss       = miss;
  assign out_item        = res_r;

endmodule

FILE: design/lpht_ctrl.sv
// Controller for the linear probing hash table: one-hot state machine that
// sequences clear pass, remainder, probe and result strobe.
// Depends on lpht_pkg.
module lpht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  lpht_pkg::in_item_t  in_item,
  input  lpht_pkg::dp_stat_t  stat,
  output lpht_pkg::ctrl_cmd_t cmd,
  output logic                busy,
  output logic                out_valid
);
  import lpht_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_HASH  = 5'b00100,
    S_PROBE = 5'b01000,
    S_EMIT  = 5'b10000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        cmd_ok;

  assign cmd_ok = (in_item.command == CMD_INSERT) || (in_item.command == CMD_DELETE) ||
                  (in_item.command == CMD_SEARCH);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = cmd_ok ? S_HASH : S_EMIT;
        end
      end
      S_HASH: begin
        cmd.hash_en = 1'b1;
        if (stat.hash_done) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe_en = 1'b1;
        if (stat.hit || stat.miss) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);

endmodule

FILE: design/linear_probe_hash_table.sv
// Linear probing hash table: an accepted item passes through remainder and probe phases
// before the out_valid strobe, probing 1 to TABLE_SIZE slots; command 3 goes straight to it.
// Throughput: one item at a time, next start taken the cycle after the strobe.
// The key remainder takes two steps (reciprocal multiply, then multiply back and subtract);
// probing reads one slot per cycle from the slot memory with registered read data.
// Reset: synchronous, active low; then a clearing pass over all TABLE_SIZE slots with busy high.
module linear_probe_hash_table #(
  parameter int TABLE_SIZE = 127
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lpht_pkg::in_item_t  in_item,
  output logic                out_valid,
  output lpht_pkg::out_item_t out_item
);
  import lpht_pkg::*;

  // Command and status bundles between the sequencer and the datapath.
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer: clear pass after reset, then accept a beat when idle, walk it
  // through remainder and probe phases, and strobe the result for one cycle.
  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Datapath: hold the slot memory ({valid, key} per slot), compute key mod
  // TABLE_SIZE by reciprocal multiplication, advance the probe address with
  // wraparound, and hold the result beat until the next item is loaded.
  lpht_dp #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

FILE: design/lpht_chk.sv
// Port-level checker for the linear probing hash table, bound to the top level.
// Depends on lpht_pkg.
module lpht_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input lpht_pkg::out_item_t out_item
);
  import lpht_pkg::*;

  // Reset always starts the clearing pass.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // An accepted beat keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // Result strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // No new beat is accepted while a result is shown.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("block idle during result strobe");

  // A found key always reports plain completion.
  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.found) |-> (out_item.status == STAT_DONE))
    else $error("found with error status");

endmodule

bind linear_probe_hash_table lpht_chk u_lpht_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

FILE: verif/linear_probe_hash_table_test.sv
`timescale 1ns / 1ps
// Self-checking bench for linear_probe_hash_table: directed and random insert, delete and
// search traffic, checked against a behavioral copy of the slot store held in a scoreboard.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
module linear_probe_hash_table_test;
  import lpht_pkg::*;

  localparam int SLOTS = 127;
  // Cycles with no accepted beat on either side before the run is declared hung.
  // A full-length probe pass and the reset clearing pass both fit well inside this limit.
  localparam int QUIET_LIMIT = 2000;
  // Drain time after the last expected result: one full-length probe pass and margin.
  localparam int TAIL_CYCLES = 200;
  localparam int PHASE_ITEMS = 400;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
  // Largest multiplier m with (SLOTS - 1) + SLOTS * m still inside KEY_W bits.
  localparam int unsigned MULT_MAX = (int'(KEY_MAX) - (SLOTS - 1)) / SLOTS;

  // Behavioral copy of the slot store plus the queue of replies still owed by the block.
  class hash_scoreboard;
    logic [KEY_W-1:0] slot_key [SLOTS];
    bit               slot_valid [SLOTS];
    out_item_t        pending_replies [$];
    int               occupancy;
    int               mismatches;

    function new();
      foreach (slot_valid[i]) begin
        slot_valid[i] = 1'b0;
        slot_key[i]   = '0;
      end
      occupancy  = 0;
      mismatches = 0;
    endfunction

    // Apply one request to the store and return the reply it must produce.
    function out_item_t predict_reply(in_item_t req);
      out_item_t   reply;
      int unsigned s;
      reply.status = STAT_DONE;
      reply.found  = 1'b0;
      s = req.key % SLOTS;
      case (req.command)
        CMD_INSERT: begin
          reply.status = STAT_FULL;
          for (int n = 0; n < SLOTS; n++) begin
            if (!slot_valid[s]) begin
              slot_valid[s] = 1'b1;
              slot_key[s]   = req.key;
              occupancy++;
              reply.status  = STAT_DONE;
              break;
            end
            s = (s + 1 == SLOTS) ? 0 : s + 1;
          end
        end
        CMD_DELETE, CMD_SEARCH: begin
          // Walk past holes: a freed slot keeps its old key but must never match.
          reply.status = STAT_ABSENT;
          for (int n = 0; n < SLOTS; n++) begin
            if (slot_valid[s] && slot_key[s] == req.key) begin
              reply.status = STAT_DONE;
              reply.found  = 1'b1;
              if (req.command == CMD_DELETE) begin
                slot_valid[s] = 1'b0;
                occupancy--;
              end
              break;
            end
            s = (s + 1 == SLOTS) ? 0 : s + 1;
          end
        end
        default: ;
      endcase
      return reply;
    endfunction

    function void note_request(in_item_t req);
      pending_replies.push_back(predict_reply(req));
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch at %0t ns: %s", $realtime, what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result beat with no request pending (status %0d found %0d)",
                                  got.status, got.found));
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.found !== want.found)
          report_mismatch($sformatf("found %0d, expected %0d", got.found, want.found));
      end
    endtask

    // Return some key that is currently stored, starting the scan at a random slot.
    function bit any_stored(output logic [KEY_W-1:0] k);
      int unsigned s;
      k = '0;
      s = $urandom_range(SLOTS - 1);
      for (int n = 0; n < SLOTS; n++) begin
        if (slot_valid[s]) begin
          k = slot_key[s];
          return 1'b1;
        end
        s = (s + 1 == SLOTS) ? 0 : s + 1;
      end
      return 1'b0;
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  hash_scoreboard sb = new();
  int sender_idle_pct;
  int quiet_cycles;

  linear_probe_hash_table #(
    .TABLE_SIZE(SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side and watchdog. Everything here reads pre-edge values, since the block
  // and the drivers only update through nonblocking assignments at this edge.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (rst_n && out_valid)
      sb.check_result(out_item);
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one request beat and hold it until the block takes it. Each cycle the sender
  // may drop start to idle; the beat counts only at an edge with start high and busy low.
  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
    in_item_t item;
    logic     offer;
    item.command = cmd;
    item.key     = key;
    in_item <= item;
    do begin
      offer = ($urandom_range(99) >= sender_idle_pct);
      start <= offer;
      @(posedge clk);
    end while (!(offer && !busy));
    sb.note_request(item);
  endtask

  // Drop start and hold off until every owed reply has come back.
  task automatic hold_until_drained();
    start <= 1'b0;
    while (sb.pending_replies.size() != 0)
      @(posedge clk);
  endtask

  // Key for a colliding cluster: a residue near the top of the table forces wraparound.
  function automatic logic [KEY_W-1:0] cluster_key();
    int unsigned residue;
    int unsigned mult;
    residue = ($urandom_range(3) == 0) ? $urandom_range(SLOTS - 1)
                                       : SLOTS - 1 - $urandom_range(6);
    mult = $urandom_range(MULT_MAX);
    return KEY_W'(residue + SLOTS * mult);
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input logic [CMD_W-1:0] cmd);
    logic [KEY_W-1:0] k;
    int unsigned      r;
    r = $urandom_range(99);
    if (r < 4)
      return (r < 2) ? '0 : KEY_MAX;
    if (cmd == CMD_INSERT) begin
      if (r < 30 && sb.any_stored(k))
        return k;              // duplicate of a stored key
      if (r < 75)
        return cluster_key();
      return KEY_W'($urandom);
    end
    if (cmd == CMD_DELETE || cmd == CMD_SEARCH) begin
      if (r < 72 && sb.any_stored(k))
        return k;              // hit
      if (r < 86 && sb.any_stored(k))
        return k + KEY_W'(SLOTS);  // same home slot, different key
      if (r < 93)
        return cluster_key();
      return KEY_W'($urandom);
    end
    return KEY_W'($urandom);
  endfunction

  // Alternate fill and drain: fill until the table has rejected a run of inserts,
  // then drain until nearly empty, so overflow and long probe chains both show up.
  task automatic run_phase(input int items);
    bit               filling;
    int               full_inserts;
    int unsigned      r;
    logic [CMD_W-1:0] cmd;
    filling      = 1'b1;
    full_inserts = 0;
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if (filling)
        cmd = (r < 78) ? CMD_INSERT : (r < 88) ? CMD_DELETE : (r < 97) ? CMD_SEARCH : CMD_UNUSED;
      else
        cmd = (r < 15) ? CMD_INSERT : (r < 75) ? CMD_DELETE : (r < 96) ? CMD_SEARCH : CMD_UNUSED;
      if (filling && cmd == CMD_INSERT && sb.occupancy == SLOTS)
        full_inserts++;
      issue(cmd, pick_key(cmd));
      if (filling && full_inserts >= 12) begin
        filling      = 1'b0;
        full_inserts = 0;
      end else if (!filling && sb.occupancy <= 4) begin
        filling = 1'b1;
      end
    end
  endtask

  initial begin
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    sender_idle_pct = 0;
    quiet_cycles    = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-table misses, collisions, wraparound, duplicates, holes left by
    // deletes, the unused command code, and a freed slot whose stale key must not match.
    issue(CMD_SEARCH, '0);
    issue(CMD_DELETE, KEY_MAX);
    issue(CMD_INSERT, '0);
    issue(CMD_INSERT, KEY_W'(SLOTS));           // collides with key 0
    issue(CMD_INSERT, KEY_MAX);
    issue(CMD_INSERT, KEY_W'(SLOTS - 1));       // last slot
    issue(CMD_INSERT, KEY_W'(2 * SLOTS - 1));   // wraps past the last slot
    issue(CMD_INSERT, '0);                      // duplicate
    issue(CMD_SEARCH, KEY_W'(2 * SLOTS - 1));
    issue(CMD_SEARCH, KEY_MAX);
    issue(CMD_DELETE, KEY_W'(SLOTS));           // opens a hole in the chain
    issue(CMD_SEARCH, KEY_W'(2 * SLOTS - 1));   // must probe across the hole
    issue(CMD_DELETE, '0);
    issue(CMD_SEARCH, '0);                      // second copy still there
    issue(CMD_DELETE, '0);
    issue(CMD_DELETE, '0);                      // now absent
    issue(CMD_UNUSED, KEY_MAX);
    issue(CMD_UNUSED, '0);
    issue(CMD_SEARCH, KEY_W'(SLOTS));           // stale key in a freed slot
    issue(CMD_SEARCH, 31'h5555_5555);
    issue(CMD_SEARCH, 31'h2AAA_AAAA);
    issue(CMD_DELETE, KEY_MAX);
    issue(CMD_SEARCH, KEY_MAX);
    hold_until_drained();

    // Random: light sender idling, then heavy, then back to back.
    sender_idle_pct = 11;
    run_phase(PHASE_ITEMS);
    hold_until_drained();
    sender_idle_pct = 51;
    run_phase(PHASE_ITEMS);
    hold_until_drained();
    sender_idle_pct = 0;
    run_phase(PHASE_ITEMS);
    hold_until_drained();

    // Watch for stray result beats after the last one owed.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: files.f
design/lpht_pkg.sv
design/lpht_dp.sv
design/lpht_ctrl.sv
design/linear_probe_hash_table.sv
design/lpht_chk.sv
verif/linear_probe_hash_table_test.sv
